### hdl/assert_macros.svh
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define PLE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define PLE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### hdl/plc_pkg.sv
// Package: sizes, codes and control types of the positional list engine.
package plc_pkg;

  localparam int CAPACITY = 128;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int LEN_W    = 8;
  localparam int DATA_W   = 32;
  localparam int POS_W    = 8;

  typedef enum logic [1:0] {
    OP_GET    = 2'd0,
    OP_INSERT = 2'd1,
    OP_DELETE = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BADPOS = 2'd1,
    ST_FULL   = 2'd2
  } status_t;

  typedef struct packed {
    logic             ins;
    logic             del;
    logic [IDX_W-1:0] slot;
  } cell_ctrl_t;

endpackage

### hdl/plc_cell.sv
// One storage cell of the list chain: holds an element, shifts with its neighbors.
module plc_cell (
  input  logic                      clk,
  input  plc_pkg::cell_ctrl_t       ctrl,
  input  logic [plc_pkg::IDX_W-1:0] cell_idx,
  input  logic signed [31:0]        from_left,
  input  logic signed [31:0]        from_right,
  input  logic signed [31:0]        ins_value,
  output logic signed [31:0]        q
);
  import plc_pkg::*;

  logic signed [DATA_W-1:0] q_next;

  always_comb begin
    q_next = q;
    priority if (ctrl.ins && (cell_idx > ctrl.slot)) begin
      q_next = from_left;
    end else if (ctrl.ins && (cell_idx == ctrl.slot)) begin
      q_next = ins_value;
    end else if (ctrl.del && (cell_idx >= ctrl.slot)) begin
      q_next = from_right;
    end else begin
      q_next = q;
    end
  end

  always_ff @(posedge clk) begin
    q <= q_next;
  end

endmodule

### hdl/positional_list_engine.sv
// Top level: ordered list of signed words held in a shifting chain of cells.
//
// Usage:
//   A request (operation, position, value) is taken at a rising edge where
//   start is high and busy is low. busy stays low: a new request may follow
//   in every cycle, so throughput is one request per clock.
//   In the cycle after a request is taken, done pulses for one cycle
//   with status, read_value and count. The receiver cannot stall; results
//   must be taken in the cycle they appear.
//   Insert and delete move every element behind the position by one cell
//   together; all cells compare their own index against the slot.
//   Get reads the addressed cell through one select into the result register.
//   Reset (rst, synchronous) empties the list and clears done. Element cells
//   are not cleared; only cells below the element count are ever read.
module positional_list_engine (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [1:0]          operation,
  input  logic [7:0]          position,
  input  logic signed [31:0]  value,
  output logic                busy,
  output logic                done,
  output logic [1:0]          status,
  output logic signed [31:0]  read_value,
  output logic [7:0]          count
);
  import plc_pkg::*;

  logic [LEN_W-1:0]         len;
  logic [LEN_W-1:0]         len_next;
  logic signed [DATA_W-1:0] cell_q [CAPACITY];
  cell_ctrl_t               ctrl;
  logic                     accept;
  logic [IDX_W-1:0]         slot;
  logic                     in_range;
  logic                     ins_range;
  logic                     full;
  status_t                  status_next;
  logic signed [DATA_W-1:0] read_next;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign slot   = IDX_W'(position - POS_W'(1));

  assign in_range  = (position != '0) && ({1'b0, position} <= {1'b0, len});
  assign ins_range = (position != '0) && ({1'b0, position} <= ({1'b0, len} + 9'd1));
  assign full      = ({1'b0, len} >= 9'(CAPACITY));

  always_comb begin
    ctrl        = '{ins: 1'b0, del: 1'b0, slot: slot};
    len_next    = len;
    status_next = ST_BADPOS;
    read_next   = '0;
    unique case (operation)
      OP_GET: begin
        if (in_range) begin
          status_next = ST_OK;
          read_next   = cell_q[slot];
        end
      end
      OP_INSERT: begin
        if (ins_range && full) begin
          status_next = ST_FULL;
        end else if (ins_range) begin
          status_next = ST_OK;
          ctrl.ins    = accept;
          len_next    = len + LEN_W'(1);
        end
      end
      OP_DELETE: begin
        if (in_range) begin
          status_next = ST_OK;
          ctrl.del    = accept;
          len_next    = len - LEN_W'(1);
        end
      end
      default: begin
        status_next = ST_BADPOS;
      end
    endcase
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [DATA_W-1:0] left_d;
    logic signed [DATA_W-1:0] right_d;
    if (i == 0) begin : g_first
      assign left_d = value;
    end else begin : g_mid_l
      assign left_d = cell_q[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_d = cell_q[i];
    end else begin : g_mid_r
      assign right_d = cell_q[i+1];
    end
    plc_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .cell_idx   (IDX_W'(i)),
      .from_left  (left_d),
      .from_right (right_d),
      .ins_value  (value),
      .q          (cell_q[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      len  <= '0;
      done <= 1'b0;
    end else begin
      done <= accept;
      if (accept) begin
        len <= len_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status     <= status_next;
      read_value <= read_next;
      count      <= len_next;
    end
  end

endmodule

### hdl/plc_checker.sv
// Port-level checker for the positional list engine, bound to the top level.
`include "assert_macros.svh"

module plc_checker (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic               done,
  input logic [1:0]         status,
  input logic signed [31:0] read_value,
  input logic [7:0]         count
);
  import plc_pkg::*;

  `PLE_ASSERT_NEXT(a_req_done, start && !busy, done, "request taken without a result")
  `PLE_ASSERT_NEXT(a_no_spurious, !(start && !busy), !done, "result without a request")
  `PLE_ASSERT_NOW(a_status_code, done, (status == ST_OK) || (status == ST_BADPOS) || (status == ST_FULL), "undefined status code")
  `PLE_ASSERT_NOW(a_fail_zero, done && (status != ST_OK), read_value == '0, "failed request returned data")
  `PLE_ASSERT_NOW(a_count_cap, done, {1'b0, count} <= 9'(CAPACITY), "count beyond capacity")

endmodule

bind positional_list_engine plc_checker u_plc_checker (.*);

### sim/list_result_checker.sv
// Checker: mirrors the positional list and compares every done pulse with its request.
`timescale 1ns / 1ps

module list_result_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  logic [1:0]         operation,
  input  logic [7:0]         position,
  input  logic signed [31:0] value,
  input  logic               done,
  input  logic [1:0]         status,
  input  logic signed [31:0] read_value,
  input  logic [7:0]         count,
  output int                 error_count,
  output int                 pending_count,
  output int                 model_length
);
  import plc_pkg::*;

  typedef struct packed {
    status_t            status;
    logic signed [31:0] rdata;
    logic [7:0]         count;
  } list_result_t;

  logic signed [31:0] cells [CAPACITY];
  int                 list_len = 0;
  list_result_t       expected_results [$];

  int err_total = 0;
  int pending_q = 0;
  int len_q     = 0;

  assign error_count   = err_total;
  assign pending_count = pending_q;
  assign model_length  = len_q;

  function automatic list_result_t apply_command(input logic [1:0] op,
                                                 input logic [7:0] pos,
                                                 input logic signed [31:0] val);
    list_result_t r;
    int p;
    p = int'(pos);
    r.status = ST_BADPOS;
    r.rdata  = '0;
    case (op)
      OP_GET: begin
        if (p != 0 && p <= list_len) begin
          r.status = ST_OK;
          r.rdata  = cells[p-1];
        end
      end
      OP_INSERT: begin
        if (p != 0 && p <= list_len + 1) begin
          if (list_len >= CAPACITY) begin
            r.status = ST_FULL;
          end else begin
            for (int k = list_len; k >= p; k--) cells[k] = cells[k-1];
            cells[p-1] = val;
            list_len++;
            r.status = ST_OK;
          end
        end
      end
      OP_DELETE: begin
        if (p != 0 && p <= list_len) begin
          for (int k = p; k < list_len; k++) cells[k-1] = cells[k];
          list_len--;
          r.status = ST_OK;
        end
      end
      default: ;
    endcase
    r.count = list_len[7:0];
    return r;
  endfunction

  always @(posedge clk) begin
    list_result_t exp_r;
    int bad;
    bad = 0;
    if (rst) begin
      list_len = 0;
      expected_results.delete();
    end else begin
      if (done) begin
        if (expected_results.size() == 0) begin
          $display("%0t: done with no request waiting (status %0d data %0d count %0d)",
                   $time, status, read_value, count);
          bad++;
        end else begin
          exp_r = expected_results.pop_front();
          if (status !== exp_r.status) begin
            $display("%0t: status expected %0d actual %0d", $time, exp_r.status, status);
            bad++;
          end
          if (read_value !== exp_r.rdata) begin
            $display("%0t: read_value expected %0d actual %0d",
                     $time, exp_r.rdata, read_value);
            bad++;
          end
          if (count !== exp_r.count) begin
            $display("%0t: count expected %0d actual %0d", $time, exp_r.count, count);
            bad++;
          end
        end
      end
      if (start && !busy) expected_results.push_back(apply_command(operation, position, value));
    end
    err_total <= err_total + bad;
    pending_q <= expected_results.size();
    len_q     <= list_len;
  end

endmodule

### sim/tb_top.sv
// Testbench top: request stimulus for the positional list engine and the final verdict.
`timescale 1ns / 1ps

module tb_top;
  import plc_pkg::*;

  localparam logic [1:0] OP_UNUSED      = 2'd3;
  localparam int         WATCHDOG_LIMIT = 1000;
  localparam int         NUM_RANDOM     = 900;
  localparam int         PHASE_LEN      = 200;

  typedef enum int {PH_GROW, PH_MIXED, PH_SHRINK} phase_t;

  logic               clk        = 1'b0;
  logic               rst        = 1'b1;
  logic               start      = 1'b0;
  logic [1:0]         operation  = OP_GET;
  logic [7:0]         position   = '0;
  logic signed [31:0] value      = '0;
  logic               busy;
  logic               done;
  logic [1:0]         status;
  logic signed [31:0] read_value;
  logic [7:0]         count;

  int error_count;
  int pending_count;
  int model_length;
  bit burst = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  positional_list_engine i_dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .operation  (operation),
    .position   (position),
    .value      (value),
    .busy       (busy),
    .done       (done),
    .status     (status),
    .read_value (read_value),
    .count      (count)
  );

  list_result_checker i_checker (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .operation     (operation),
    .position      (position),
    .value         (value),
    .done          (done),
    .status        (status),
    .read_value    (read_value),
    .count         (count),
    .error_count   (error_count),
    .pending_count (pending_count),
    .model_length  (model_length)
  );

  task automatic send_request(input logic [1:0] op, input logic [7:0] pos,
                              input logic signed [31:0] val);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start     <= 1'b1;
    operation <= op;
    position  <= pos;
    value     <= val;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
  endtask

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'sh7fffffff;
      1:       return 32'sh80000000;
      2:       return 32'sh0;
      3:       return -32'sd1;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [1:0] pick_op(input phase_t ph);
    int r;
    r = $urandom_range(0, 99);
    if (ph != PH_GROW && r == 0) return OP_UNUSED;
    case (ph)
      PH_GROW:   return (r < 80) ? OP_INSERT : (r < 90) ? OP_GET : OP_DELETE;
      PH_SHRINK: return (r < 80) ? OP_DELETE : (r < 90) ? OP_GET : OP_INSERT;
      default:   return (r < 40) ? OP_GET : (r < 70) ? OP_INSERT : OP_DELETE;
    endcase
  endfunction

  function automatic logic [7:0] pick_position(input logic [1:0] op, input int len);
    int r;
    int top;
    r   = $urandom_range(0, 99);
    top = (op == OP_INSERT) ? len + 1 : len;
    if (top < 1) top = 1;
    if (r < 80) return 8'($urandom_range(1, top));
    if (r < 88) return 8'd0;
    if (r < 94) return 8'(top + $urandom_range(0, 1));
    return 8'($urandom_range(0, 255));
  endfunction

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (start && !busy) || done) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  initial begin : stimulus
    phase_t     ph;
    logic [1:0] op;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty list, boundaries, both extremes of value, unused opcode
    send_request(OP_GET,    8'd1,   32'sd5);
    send_request(OP_DELETE, 8'd1,   32'sd0);
    send_request(OP_INSERT, 8'd0,   32'sd7);
    send_request(OP_INSERT, 8'd2,   32'sd7);
    send_request(OP_INSERT, 8'd1,   32'sh7fffffff);
    send_request(OP_INSERT, 8'd1,   32'sh80000000);
    send_request(OP_INSERT, 8'd3,   -32'sd1);
    send_request(OP_INSERT, 8'd2,   32'sd0);
    send_request(OP_INSERT, 8'd255, 32'sd9);
    send_request(OP_GET,    8'd1,   32'sd0);
    send_request(OP_GET,    8'd2,   32'sd0);
    send_request(OP_GET,    8'd3,   32'sd0);
    send_request(OP_GET,    8'd4,   32'sd0);
    send_request(OP_GET,    8'd0,   32'sd0);
    send_request(OP_GET,    8'd5,   32'sd0);
    send_request(OP_GET,    8'd255, 32'sh7fffffff);
    send_request(OP_UNUSED, 8'd1,   32'sd3);
    send_request(OP_DELETE, 8'd0,   32'sd0);
    send_request(OP_DELETE, 8'd5,   32'sd0);
    send_request(OP_DELETE, 8'd255, 32'sd0);
    send_request(OP_DELETE, 8'd2,   32'sd0);
    send_request(OP_DELETE, 8'd1,   32'sd0);
    send_request(OP_GET,    8'd1,   32'sd0);
    drain_results();

    // directed: fill to capacity, full and position checks at the top end, empty again
    for (int i = 0; i < CAPACITY; i++) send_request(OP_INSERT, 8'd1, pick_value());
    send_request(OP_INSERT, 8'd1,              pick_value());
    send_request(OP_INSERT, 8'(CAPACITY + 1),  pick_value());
    send_request(OP_INSERT, 8'(CAPACITY + 2),  pick_value());
    send_request(OP_GET,    8'(CAPACITY),      32'sd0);
    send_request(OP_DELETE, 8'(CAPACITY),      32'sd0);
    send_request(OP_INSERT, 8'(CAPACITY),      pick_value());
    for (int i = 0; i < CAPACITY; i++) send_request(OP_DELETE, 8'(CAPACITY - i), 32'sd0);
    send_request(OP_GET,    8'd1,              32'sd0);
    drain_results();

    for (int i = 0; i < NUM_RANDOM; i++) begin
      if (i % 50 == 0) burst = ($urandom_range(0, 3) == 0);
      if (i % PHASE_LEN == 0) begin
        drain_results();
        case ((i / PHASE_LEN) % 3)
          0:       ph = PH_GROW;
          1:       ph = PH_MIXED;
          default: ph = PH_SHRINK;
        endcase
      end
      op = pick_op(ph);
      send_request(op, pick_position(op, model_length), pick_value());
    end

    drain_results();
    repeat (8) @(posedge clk);
    if (error_count == 0 && pending_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
